// ----- rtl/smlc_pkg.sv -----
// shared types and constants for the softmax linear classifier
package smlc_pkg;

    localparam int DEF_FEATURE_COUNT = 1024;
    localparam int DEF_CLASS_COUNT   = 16;
    localparam int QDEPTH            = 4;
    localparam int CMP_W             = 8;
    localparam int CFG_IDX_W         = 2;

    localparam logic [23:0] COUNT_MAX     = 24'hFFFFFF;
    localparam logic [12:0] LOG2E_Q12     = 13'd5909;
    localparam logic [15:0] LR_RESET      = 16'd66;
    localparam logic [4:0]  CLASSES_RESET = 5'd10;

    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLASSES_IN_USE = 2'd2;

    typedef struct packed {
        logic signed [15:0] feature;
        logic [3:0]         label;
        logic               is_last;
        logic               restart_counts;
    } smlc_item_t;

    typedef struct packed {
        logic        train_enable;
        logic [15:0] step_size;
        logic [4:0]  classes_in_use;
    } smlc_cfg_t;

    typedef struct packed {
        logic [3:0]  predicted_class;
        logic        correct;
        logic [23:0] correct_count;
        logic [23:0] sample_count;
    } smlc_result_t;

    typedef struct packed {
        logic clearing;
    } smlc_status_t;

endpackage

// ----- rtl/smlc_front.sv -----
// input side: accepts feature requests into a short queue
module smlc_front
    import smlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tuser,
    input  logic        hold,
    output logic        q_valid,
    output smlc_item_t  q_item,
    input  logic        q_pop
);

    localparam int QA_W = $clog2(QDEPTH);

    smlc_item_t           slot_reg [QDEPTH];
    logic [QA_W-1:0]      wr_ptr_reg;
    logic [QA_W-1:0]      rd_ptr_reg;
    logic [QA_W:0]        cnt_reg;
    logic                 push;
    smlc_item_t           in_item;

    assign s_tready = (cnt_reg != (QA_W+1)'(QDEPTH)) && !hold;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.feature        = $signed(s_tdata[15:0]);
        in_item.label          = s_tdata[19:16];
        in_item.is_last        = s_tlast;
        in_item.restart_counts = s_tuser;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!push && q_pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/smlc_back.sv -----
// engine: logit accumulation, argmax, counters and sgd update
module smlc_back
    import smlc_pkg::*;
#(
    parameter int FEATURE_COUNT = DEF_FEATURE_COUNT,
    parameter int CLASS_COUNT   = DEF_CLASS_COUNT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  smlc_item_t   q_item,
    output logic         q_pop,
    input  smlc_cfg_t    cfg,
    output logic         res_valid,
    output smlc_result_t res,
    input  logic         res_ready,
    output smlc_status_t status
);

    localparam int FI_W    = $clog2(FEATURE_COUNT + 1);
    localparam int FA_W    = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int CI_W    = $clog2(CLASS_COUNT);
    localparam int CU_W    = $clog2(CLASS_COUNT + 1);
    localparam int WA_W    = FA_W + CI_W;
    localparam int W_DEPTH = FEATURE_COUNT * (2 ** CI_W);
    localparam logic [CI_W-1:0] CLS_LAST = CI_W'(CLASS_COUNT - 1);
    localparam logic [WA_W-1:0] CLR_LAST = WA_W'(W_DEPTH - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MAC   = 4'd2;
    localparam logic [3:0] S_ARG   = 4'd3;
    localparam logic [3:0] S_OUT   = 4'd4;
    localparam logic [3:0] S_EXP0  = 4'd5;
    localparam logic [3:0] S_EXP1  = 4'd6;
    localparam logic [3:0] S_DINIT = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_STEP  = 4'd9;
    localparam logic [3:0] S_BIAS  = 4'd10;
    localparam logic [3:0] S_WRD   = 4'd11;
    localparam logic [3:0] S_WMUL  = 4'd12;
    localparam logic [3:0] S_WWR   = 4'd13;

    // storage
    logic signed [15:0] wmem [W_DEPTH];
    logic signed [15:0] fbuf [FEATURE_COUNT];
    logic signed [15:0] w_rdata_reg;
    logic signed [15:0] f_rdata_reg;
    logic signed [15:0] bias_reg  [CLASS_COUNT];
    logic signed [31:0] logit_reg [CLASS_COUNT];
    logic [16:0]        e_reg     [CLASS_COUNT];

    // control
    logic [3:0]         state_reg;
    logic [WA_W-1:0]    clr_reg;
    logic [FI_W-1:0]    elem_reg;
    logic [FI_W-1:0]    count_reg;
    logic [FI_W-1:0]    f_reg;
    logic [CI_W-1:0]    cls_reg;
    logic [CU_W-1:0]    used_reg;
    logic [CI_W-1:0]    pred_reg;
    logic signed [31:0] top_reg;
    logic               first_reg;
    logic               last_reg;
    logic [3:0]         label_reg;
    logic signed [15:0] x_reg;
    logic [15:0]        lr_reg;
    logic [23:0]        ccount_reg;
    logic [23:0]        scount_reg;
    logic [33:0]        y_reg;
    logic [20:0]        sum_reg;
    logic [32:0]        num_reg;
    logic [20:0]        rem_reg;
    logic [5:0]         div_cnt_reg;
    logic signed [34:0] step_reg;
    logic signed [50:0] wprod_reg;

    // memory port signals
    logic               w_we;
    logic [WA_W-1:0]    w_waddr;
    logic signed [15:0] w_wdata;
    logic               w_re;
    logic [WA_W-1:0]    w_raddr;
    logic               f_we;
    logic               f_re;

    // datapath
    logic               elem_ok;
    logic [FA_W-1:0]    elem_fa;
    logic [FA_W-1:0]    f_fa;
    logic [CU_W-1:0]    used_calc;
    logic               cls_is_last_used;
    logic signed [31:0] lg_cur;
    logic signed [31:0] mac_prod;
    logic signed [32:0] mac_sum;
    logic signed [31:0] mac_sat;
    logic [32:0]        exp_d;
    logic [45:0]        exp_prod;
    logic [21:0]        exp_n;
    logic [16:0]        exp_e;
    logic [21:0]        rem_sh;
    logic [21:0]        den;
    logic               div_ge;
    logic [15:0]        prob;
    logic signed [17:0] grad;
    logic signed [34:0] bias_rnd;
    logic signed [16:0] bias_new;
    logic signed [15:0] bias_sat;
    logic signed [50:0] wprod;
    logic signed [50:0] w_rnd;
    logic signed [19:0] w_new;
    logic signed [15:0] w_sat;
    logic               hit;
    logic [23:0]        scount_inc;
    logic [23:0]        ccount_inc;
    logic [CMP_W-1:0]   cls_in_w;

    assign elem_ok  = (elem_reg < FI_W'(FEATURE_COUNT));
    assign elem_fa  = elem_reg[FA_W-1:0];
    assign f_fa     = f_reg[FA_W-1:0];
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign lg_cur   = logit_reg[cls_reg];
    assign cls_in_w = CMP_W'(cfg.classes_in_use);
    assign cls_is_last_used = (CMP_W'(cls_reg) == CMP_W'(used_reg) - 1'b1);
    assign status.clearing  = (state_reg == S_CLEAR);

    // classes in use, clamped to [2, CLASS_COUNT]
    always_comb
    begin
        if (cls_in_w < CMP_W'(2))
        begin
            used_calc = CU_W'(2);
        end
        else if (cls_in_w > CMP_W'(CLASS_COUNT))
        begin
            used_calc = CU_W'(CLASS_COUNT);
        end
        else
        begin
            used_calc = CU_W'(cls_in_w);
        end
    end

    // one class of the logit update
    always_comb
    begin
        mac_prod = x_reg * w_rdata_reg;
        if (first_reg)
        begin
            mac_sum = 33'(bias_reg[cls_reg]) + 33'($signed(mac_prod[31:12]));
        end
        else
        begin
            mac_sum = 33'(lg_cur) + 33'($signed(mac_prod[31:12]));
        end
        if (mac_sum[32] != mac_sum[31])
        begin
            mac_sat = mac_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            mac_sat = mac_sum[31:0];
        end
    end

    // exp approximation, split across S_EXP0 and S_EXP1 by the y_reg register
    always_comb
    begin
        exp_d    = 33'($signed(top_reg)) - 33'($signed(lg_cur));
        exp_prod = 46'(exp_d) * 46'(LOG2E_Q12);
        exp_n    = y_reg[33:12];
        if (exp_n >= 22'd17)
        begin
            exp_e = '0;
        end
        else
        begin
            exp_e = (17'd65536 - {2'b00, y_reg[11:0], 3'b000}) >> exp_n[4:0];
        end
    end

    // restoring divider step and sgd arithmetic
    always_comb
    begin
        den    = (sum_reg == '0) ? 22'd1 : {1'b0, sum_reg};
        rem_sh = {rem_reg, num_reg[32]};
        div_ge = (rem_sh >= den);
        prob   = (num_reg[32:16] != '0) ? 16'hFFFF : num_reg[15:0];
        if (CMP_W'(cls_reg) == CMP_W'(label_reg))
        begin
            grad = $signed({2'b00, prob}) - 18'sd65536;
        end
        else
        begin
            grad = $signed({2'b00, prob});
        end
        bias_rnd = step_reg + 35'sd524288;
        bias_new = 17'(bias_reg[cls_reg]) - 17'($signed(bias_rnd[34:20]));
        if (bias_new > 17'sd32767)
        begin
            bias_sat = 16'sh7FFF;
        end
        else if (bias_new < -17'sd32768)
        begin
            bias_sat = 16'sh8000;
        end
        else
        begin
            bias_sat = bias_new[15:0];
        end
        wprod = step_reg * f_rdata_reg;
        w_rnd = wprod_reg + 51'sd2147483648;
        w_new = 20'(w_rdata_reg) - 20'($signed(w_rnd[50:32]));
        if (w_new > 20'sd32767)
        begin
            w_sat = 16'sh7FFF;
        end
        else if (w_new < -20'sd32768)
        begin
            w_sat = 16'sh8000;
        end
        else
        begin
            w_sat = w_new[15:0];
        end
    end

    // counters and result
    always_comb
    begin
        hit        = (CMP_W'(pred_reg) == CMP_W'(label_reg));
        scount_inc = (scount_reg == COUNT_MAX) ? scount_reg : scount_reg + 1'b1;
        ccount_inc = (hit && ccount_reg != COUNT_MAX) ? ccount_reg + 1'b1 : ccount_reg;
        res_valid  = (state_reg == S_OUT);
        res.predicted_class = 4'(pred_reg);
        res.correct         = hit;
        res.correct_count   = ccount_inc;
        res.sample_count    = scount_inc;
    end

    // memory port control
    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = {f_fa, cls_reg};
        w_wdata = w_sat;
        w_re    = 1'b0;
        w_raddr = {elem_fa, cls_reg + 1'b1};
        f_we    = 1'b0;
        f_re    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                w_we    = 1'b1;
                w_waddr = clr_reg;
                w_wdata = '0;
            end
            S_IDLE:
            begin
                if (q_pop && elem_ok)
                begin
                    w_re    = 1'b1;
                    w_raddr = {elem_fa, CI_W'(0)};
                    f_we    = 1'b1;
                end
            end
            S_MAC:
            begin
                w_re = 1'b1;
            end
            S_WRD:
            begin
                w_re    = 1'b1;
                w_raddr = {f_fa, cls_reg};
                f_re    = 1'b1;
            end
            S_WWR:
            begin
                w_we = 1'b1;
            end
            default:
            begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[w_waddr] <= w_wdata;
        end
        if (w_re)
        begin
            w_rdata_reg <= wmem[w_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fbuf[elem_fa] <= q_item.feature;
        end
        if (f_re)
        begin
            f_rdata_reg <= fbuf[f_fa];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXP1)
        begin
            e_reg[cls_reg] <= exp_e;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            elem_reg   <= '0;
            ccount_reg <= '0;
            scount_reg <= '0;
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                bias_reg[i]  <= '0;
                logit_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        x_reg     <= q_item.feature;
                        label_reg <= q_item.label;
                        last_reg  <= q_item.is_last;
                        if (q_item.restart_counts)
                        begin
                            ccount_reg <= '0;
                            scount_reg <= '0;
                        end
                        cls_reg <= '0;
                        if (elem_ok)
                        begin
                            first_reg <= (elem_reg == '0);
                            state_reg <= S_MAC;
                        end
                        else if (q_item.is_last)
                        begin
                            count_reg <= elem_reg;
                            elem_reg  <= '0;
                            used_reg  <= used_calc;
                            state_reg <= S_ARG;
                        end
                    end
                end
                S_MAC:
                begin
                    logit_reg[cls_reg] <= mac_sat;
                    if (cls_reg == CLS_LAST)
                    begin
                        cls_reg <= '0;
                        if (last_reg)
                        begin
                            count_reg <= elem_reg + 1'b1;
                            elem_reg  <= '0;
                            used_reg  <= used_calc;
                            state_reg <= S_ARG;
                        end
                        else
                        begin
                            elem_reg  <= elem_reg + 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        cls_reg <= cls_reg + 1'b1;
                    end
                end
                S_ARG:
                begin
                    if (cls_reg == '0 || lg_cur > top_reg)
                    begin
                        top_reg  <= lg_cur;
                        pred_reg <= cls_reg;
                    end
                    if (cls_is_last_used)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cls_reg <= cls_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        scount_reg <= scount_inc;
                        ccount_reg <= ccount_inc;
                        lr_reg     <= cfg.step_size;
                        cls_reg    <= '0;
                        sum_reg    <= '0;
                        state_reg  <= cfg.train_enable ? S_EXP0 : S_IDLE;
                    end
                end
                S_EXP0:
                begin
                    y_reg     <= exp_prod[45:12];
                    state_reg <= S_EXP1;
                end
                S_EXP1:
                begin
                    sum_reg <= sum_reg + 21'(exp_e);
                    if (cls_is_last_used)
                    begin
                        cls_reg   <= '0;
                        state_reg <= S_DINIT;
                    end
                    else
                    begin
                        cls_reg   <= cls_reg + 1'b1;
                        state_reg <= S_EXP0;
                    end
                end
                S_DINIT:
                begin
                    num_reg     <= {e_reg[cls_reg], 16'h0000};
                    rem_reg     <= '0;
                    div_cnt_reg <= 6'd33;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    num_reg     <= {num_reg[31:0], div_ge};
                    rem_reg     <= div_ge ? 21'(rem_sh - den) : rem_sh[20:0];
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == 6'd1)
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    step_reg  <= $signed({1'b0, lr_reg}) * grad;
                    state_reg <= S_BIAS;
                end
                S_BIAS:
                begin
                    bias_reg[cls_reg] <= bias_sat;
                    f_reg             <= '0;
                    state_reg         <= (count_reg == '0) ? S_IDLE : S_WRD;
                end
                S_WRD:
                begin
                    state_reg <= S_WMUL;
                end
                S_WMUL:
                begin
                    wprod_reg <= wprod;
                    state_reg <= S_WWR;
                end
                S_WWR:
                begin
                    if (f_reg + 1'b1 == count_reg)
                    begin
                        if (cls_is_last_used)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            cls_reg   <= cls_reg + 1'b1;
                            state_reg <= S_DINIT;
                        end
                    end
                    else
                    begin
                        f_reg     <= f_reg + 1'b1;
                        state_reg <= S_WRD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // clearing pass runs once after reset
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("weight clearing pass restarted");

    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        elem_reg <= FI_W'(FEATURE_COUNT))
        else $error("element index past feature count");

    a_pred_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (CMP_W'(pred_reg) < CMP_W'(used_reg)))
        else $error("predicted class outside classes in use");

    a_write_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WWR) |-> ($past(state_reg) == S_WMUL))
        else $error("weight write without fresh product");

endmodule

// ----- rtl/softmax_linear_classifier_sgd.sv -----
// top level: softmax classifier with on-line sgd, config registers and result register
//
// A sample is a run of feature requests (signed Q4.12) closed by tlast, which carries
// the label. For each element the engine does one weight memory read and one
// multiply-accumulate per class, all classes every element. The last element adds an
// argmax over the used classes, and then one result request leaves through the output
// register. With train_enable set the engine then runs the update: exp per class, then
// per class the 33-step divider, step and bias update, plus a weight read-modify-write
// per buffered feature. A four-deep queue sits in front of the engine so input keeps
// flowing while it works. After reset the weight memory is swept to zero, all
// FEATURE_COUNT*2^ceil(log2(CLASS_COUNT)) entries (16384 at default); s_tready stays
// low during that pass while configuration writes are still taken.
module softmax_linear_classifier_sgd
    import smlc_pkg::*;
#(
    parameter int FEATURE_COUNT = DEF_FEATURE_COUNT,
    parameter int CLASS_COUNT   = DEF_CLASS_COUNT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // feature[15:0], label[19:16], zero fill
    input  logic                 s_tlast,   // is_last
    input  logic                 s_tuser,   // restart_counts
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata    // predicted_class[3:0], correct[4],
                                            // correct_count[28:5], sample_count[52:29]
);

    smlc_cfg_t    cfg_reg;
    smlc_item_t   q_item;
    logic         q_valid;
    logic         q_pop;
    logic         res_valid;
    logic         res_ready;
    smlc_result_t res;
    smlc_result_t out_reg;
    logic         out_valid_reg;
    smlc_status_t status;

    // config writes always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.train_enable   <= 1'b0;
            cfg_reg.step_size      <= LR_RESET;
            cfg_reg.classes_in_use <= CLASSES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TRAIN_ENABLE:   cfg_reg.train_enable   <= cfg_data[0];
                REG_STEP_SIZE:      cfg_reg.step_size      <= cfg_data;
                REG_CLASSES_IN_USE: cfg_reg.classes_in_use <= cfg_data[4:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: input queue, held off while the weight memory is cleared
    smlc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .hold     (status.clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: accumulation, argmax, counters and training
    smlc_back #(
        .FEATURE_COUNT (FEATURE_COUNT),
        .CLASS_COUNT   (CLASS_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .status    (status)
    );

    // output register decouples the result request from the engine
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.sample_count, out_reg.correct_count,
                       out_reg.correct, out_reg.predicted_class};

endmodule

// ----- dv/smlc_checker.sv -----
// checker for the softmax classifier: mirrors the channels, predicts results and compares them
module smlc_checker
    import smlc_pkg::*;
#(
    parameter int FC = DEF_FEATURE_COUNT,
    parameter int CC = DEF_CLASS_COUNT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [23:0]          s_tdata,
    input  logic                 s_tlast,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [55:0]          m_tdata,
    output int                   fails,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [15:0] wts [FC*CC];
    logic signed [15:0] bias [CC];
    logic signed [15:0] fbuf [FC];
    logic signed [31:0] logit [CC];
    int                 elem;
    logic [23:0]        n_ok;
    logic [23:0]        n_all;
    logic               train_en;
    logic [15:0]        lrate;
    logic [4:0]         cls_cfg;
    smlc_result_t       due_q [$];

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void sgd_update(int used, int label, int count);
        longint e [CC];
        longint sum, top, d, y, n, f, p, g, stp;
        sum = 0;
        top = logit[0];
        for (int c = 1; c < used; c++)
            if (logit[c] > top)
                top = logit[c];
        for (int c = 0; c < used; c++)
        begin
            d = longint'(logit[c]) - top;
            y = (-d * 5909) >>> 12;
            n = y >>> 12;
            f = y & 4095;
            e[c] = (n >= 17) ? 0 : ((65536 - 8 * f) >> n);
            sum += e[c];
        end
        if (sum == 0)
            sum = 1;
        for (int c = 0; c < used; c++)
        begin
            p = (e[c] << 16) / sum;
            if (p > 65535)
                p = 65535;
            g = p - ((c == label) ? 65536 : 0);
            stp = longint'(lrate) * g;
            bias[c] = 16'(clamp(longint'(bias[c]) - ((stp + (longint'(1) << 19)) >>> 20),
                                -32768, 32767));
            for (int k = 0; k < count; k++)
            begin
                d = (stp * longint'(fbuf[k]) + (longint'(1) << 31)) >>> 32;
                wts[k*CC+c] = 16'(clamp(longint'(wts[k*CC+c]) - d, -32768, 32767));
            end
        end
    endfunction

    // one accepted element; returns 1 and fills r when it closes a sample
    function automatic bit classify(smlc_item_t it, output smlc_result_t r);
        longint x, s;
        int used, pred, count;
        x = longint'(it.feature);
        r = '0;
        if (it.restart_counts)
        begin
            n_ok  = '0;
            n_all = '0;
        end
        if (elem == 0)
            for (int c = 0; c < CC; c++)
                logit[c] = 32'(bias[c]);
        // elements past the buffer depth are dropped
        if (elem < FC)
        begin
            fbuf[elem] = it.feature;
            for (int c = 0; c < CC; c++)
            begin
                s = longint'(logit[c]) + ((x * longint'(wts[elem*CC+c])) >>> 12);
                logit[c] = 32'(clamp(s, -64'sd2147483648, 64'sd2147483647));
            end
            elem++;
        end
        if (!it.is_last)
            return 0;
        count = elem;
        elem  = 0;
        used  = (cls_cfg < 2) ? 2 : ((cls_cfg > CC) ? CC : int'(cls_cfg));
        pred  = 0;
        for (int c = 1; c < used; c++)
            if (logit[c] > logit[pred])
                pred = c;
        r.predicted_class = 4'(pred);
        r.correct         = (pred == int'(it.label));
        if (n_all < COUNT_MAX)
            n_all++;
        if (r.correct && n_ok < COUNT_MAX)
            n_ok++;
        r.correct_count = n_ok;
        r.sample_count  = n_all;
        if (train_en)
            sgd_update(used, int'(it.label), count);
        return 1;
    endfunction

    assign pending = due_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        smlc_item_t   it;
        smlc_result_t r;
        smlc_result_t got;
        if (!rst_n)
        begin
            foreach (wts[i]) wts[i] = '0;
            foreach (bias[i]) bias[i] = '0;
            foreach (logit[i]) logit[i] = '0;
            elem     = 0;
            n_ok     = '0;
            n_all    = '0;
            train_en = 1'b0;
            lrate    = LR_RESET;
            cls_cfg  = CLASSES_RESET;
            fails    = 0;
            due_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_TRAIN_ENABLE:   train_en = cfg_data[0];
                    REG_STEP_SIZE:      lrate    = cfg_data;
                    REG_CLASSES_IN_USE: cls_cfg  = cfg_data[4:0];
                    default: ;
                endcase
            if (s_tvalid && s_tready)
            begin
                it.feature        = s_tdata[15:0];
                it.label          = s_tdata[19:16];
                it.is_last        = s_tlast;
                it.restart_counts = s_tuser;
                if (classify(it, r))
                    due_q.push_back(r);
            end
            if (m_tvalid && m_tready)
            begin
                got.predicted_class = m_tdata[3:0];
                got.correct         = m_tdata[4];
                got.correct_count   = m_tdata[28:5];
                got.sample_count    = m_tdata[52:29];
                if (due_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result request %h", m_tdata);
                end
                else
                begin
                    r = due_q.pop_front();
                    if (got !== r)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("mismatch exp: class %0d correct %0d ok %0d all %0d",
                                     r.predicted_class, r.correct, r.correct_count,
                                     r.sample_count);
                            $display("         act: class %0d correct %0d ok %0d all %0d",
                                     got.predicted_class, got.correct, got.correct_count,
                                     got.sample_count);
                        end
                    end
                end
            end
        end
    end
endmodule

// ----- dv/tb.sv -----
// testbench top for the softmax classifier: stimulus, result back-pressure and verdict
module tb;
    import smlc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FC        = DEF_FEATURE_COUNT;
    localparam int IDLE_MAX  = 400000;   // no-progress limit, covers the clearing sweep

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;
    logic                 s_tlast;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [55:0]          m_tdata;
    int                   fails;
    int                   pending;
    int                   idle_cycles;
    int                   last_len;    // length of the most recent sample, sets drain time
    int                   sent;
    bit                   hold_req;    // asks the receiver for one long hold-off
    bit                   hold_on;     // receiver is in its long hold-off

    softmax_linear_classifier_sgd DUT (.*);

    smlc_checker CHK (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // gap lengths: mostly none or short, now and then long
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // features: extremes, small values or anything
    function automatic logic [15:0] pick_feature();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3, 4:    return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom());
        endcase
    endfunction

    // one element request, held until taken
    task automatic send_elem(logic [15:0] feat, logic [3:0] label, bit last, bit restart);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, label, feat};
        s_tlast  <= last;
        s_tuser  <= restart;
        do @(posedge clk); while (!s_tready);
        sent++;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // one sample of len elements, label on the closing one
    task automatic send_sample(int len, logic [3:0] label, bit restart);
        for (int i = 0; i < len; i++)
            send_elem(pick_feature(), label, i == len - 1,
                      (i == 0 && restart) || ($urandom_range(0, 63) == 0));
        last_len = len;
    endtask

    // all results in, then room for the sgd pass of the last sample
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16 * (40 + 3 * (last_len < FC ? last_len : FC)) + 64) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(logic te, logic [15:0] lr, logic [4:0] cls);
        drain();
        cfg_write(REG_TRAIN_ENABLE, {15'b0, te});
        cfg_write(REG_STEP_SIZE, lr);
        cfg_write(REG_CLASSES_IN_USE, {11'b0, cls});
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        hold_on  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                hold_on = 1'b1;
                repeat (3000) @(posedge clk);
                hold_on  = 1'b0;
                hold_req = 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
                if ($urandom_range(0, 3) != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap_len() + 1) @(posedge clk);
                end
            end
        end
    end

    // watchdog on progress across all three channels
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] lr;
        logic [4:0]  cls;
        int          len;
        bit          waited;
        bit          held;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        s_tuser     = 1'b0;
        idle_cycles = 0;
        last_len    = 1;
        sent        = 0;
        hold_req    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, extremes of feature and label
        send_elem(16'h7FFF, 4'd0, 1'b1, 1'b1);
        send_elem(16'h8000, 4'd15, 1'b0, 1'b0);   // label outside the ten classes in use
        send_elem(16'h0000, 4'd15, 1'b1, 1'b0);
        last_len = 2;

        // hard training, all classes, so weights and biases run into saturation
        set_all(1'b1, 16'hFFFF, 5'd16);
        send_elem(16'h7FFF, 4'd3, 1'b1, 1'b0);
        send_elem(16'h8000, 4'd15, 1'b1, 1'b0);
        send_elem(16'h7FFF, 4'd15, 1'b0, 1'b0);
        send_elem(16'h8000, 4'd0, 1'b1, 1'b1);
        send_elem(16'h7FFF, 4'd9, 1'b1, 1'b0);
        last_len = 2;

        // class counts below two and above sixteen get clamped
        set_all(1'b1, 16'd1, 5'd0);
        send_sample(3, 4'd1, 1'b0);
        drain();
        cfg_write(REG_CLASSES_IN_USE, 16'd31);
        send_sample(3, 4'd15, 1'b0);
        drain();
        cfg_write(REG_CLASSES_IN_USE, 16'd1);
        send_sample(2, 4'd0, 1'b0);

        // overlong sample: elements past the buffer depth are dropped
        set_all(1'b1, 16'd0, 5'd17);
        send_sample(FC + 6, 4'd5, 1'b0);

        // random phases, extremes first
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       begin lr = 16'hFFFF; cls = 5'd16; end
                1:       begin lr = 16'd1;    cls = 5'd2;  end
                default: begin lr = 16'($urandom()); cls = 5'($urandom_range(0, 31)); end
            endcase
            set_all(ph == 7 ? 1'b0 : 1'($urandom_range(0, 1)), lr, cls);
            sent   = 0;
            waited = 1'b0;
            held   = 1'b0;
            while (sent < 20)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 48)
                                                    : $urandom_range(1, 6);
                send_sample(len, 4'($urandom_range(0, 15)), $urandom_range(0, 15) == 0);
                if (!waited && sent >= 10)
                begin
                    // sender waits out every outstanding result
                    waited = 1'b1;
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
                // long receiver hold-off while single-element samples keep coming
                if (ph == 7 && !held && sent >= 5)
                begin
                    held     = 1'b1;
                    s_tvalid <= 1'b0;
                    hold_req = 1'b1;
                    wait (hold_on);
                    repeat (12) send_sample(1, 4'($urandom_range(0, 15)), 1'b0);
                end
            end
        end

        drain();
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
